>>> rtl/wbss_pkg.sv
// Shared types and constants for the wildcard byte signature scanner.
// No dependencies; imported by every module of the block.
package wbss_pkg;

    localparam int SIG_BYTES = 16;
    localparam int SIG_IDX_W = 4;
    localparam int CFG_W     = 64;
    localparam int ADDR_W    = 32;
    localparam int LEN_W     = 5;
    localparam int WILD_W    = 16;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_PAT_LO  = 3'd0,
        CFG_PAT_HI  = 3'd1,
        CFG_WILD    = 3'd2,
        CFG_LEN     = 3'd3,
        CFG_START   = 3'd4,
        CFG_END     = 3'd5
    } t_cfg_idx;

    // Signature bytes, byte 0 in the low bits
    typedef logic [SIG_BYTES-1:0][7:0] t_sig;

    // Per-cycle control for every cell of the window
    typedef struct packed {
        logic load;
        logic clear;
    } t_cell_ctl;

endpackage

>>> rtl/wildcard_byte_signature_scanner.sv
// Wildcard byte signature scanner: bytes pass through a row of cells.
// A result appears on o_valid in the cycle after the byte that ends it.
// Throughput: one byte per cycle while o_ready is high; the masked compare across
// the cell row and the address subtract are combinational before the output register.
// Reset (synchronous, active low): block idle until scan_start, config
// registers at reset values, no result pending.
module wildcard_byte_signature_scanner import wbss_pkg::*; #(
    parameter int MAX_PATTERN = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_data_byte,
    input  logic              i_scan_start,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_found,
    output logic [ADDR_W-1:0] o_match_address
);

    localparam int CNT_W = $clog2(MAX_PATTERN + 1);

    // Configuration registers
    logic [CFG_W-1:0]  r_pat_lo;
    logic [CFG_W-1:0]  r_pat_hi;
    logic [WILD_W-1:0] r_wild;
    logic [LEN_W-1:0]  r_len;
    logic [ADDR_W-1:0] r_start_addr;
    logic [ADDR_W-1:0] r_end_addr;

    // Scan state
    logic [ADDR_W-1:0] r_cur;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_finished;

    // Output register
    logic              r_out_valid;
    logic              r_out_found;
    logic [ADDR_W-1:0] r_out_addr;

    logic              w_accept;
    logic              w_active;
    logic              w_empty;
    logic              w_match;
    logic              w_at_end;
    logic [ADDR_W-1:0] w_cur;
    logic [CNT_W-1:0]  n_cnt;
    logic [LEN_W-1:0]  w_len;
    t_sig              w_sig;
    t_cell_ctl         w_ctl;

    logic [MAX_PATTERN-1:0][7:0] w_in;
    logic [MAX_PATTERN-1:0][7:0] w_q;
    logic [MAX_PATTERN-1:0]      w_hit;

    assign o_ready  = !r_out_valid || i_ready;
    assign w_accept = i_valid && o_ready;
    assign w_active = w_accept && (i_scan_start || !r_finished);

    // Clamp the signature length to the cell count; zero acts as one
    always_comb begin
        if (r_len == LEN_W'(0)) begin
            w_len = LEN_W'(1);
        end else if (r_len > LEN_W'(MAX_PATTERN)) begin
            w_len = LEN_W'(MAX_PATTERN);
        end else begin
            w_len = r_len;
        end
    end

    assign w_sig   = {r_pat_hi, r_pat_lo};
    assign w_cur   = i_scan_start ? r_start_addr : r_cur;
    assign w_empty = i_scan_start && (r_end_addr <= r_start_addr);

    // Fill count after this byte, saturating at the cell count
    always_comb begin
        if (i_scan_start) begin
            n_cnt = CNT_W'(1);
        end else if (r_cnt == CNT_W'(MAX_PATTERN)) begin
            n_cnt = r_cnt;
        end else begin
            n_cnt = r_cnt + CNT_W'(1);
        end
    end

    assign w_ctl.clear = w_active && w_empty;
    assign w_ctl.load  = w_active && !w_empty;

    // Row of window cells; a scan start shifts zeros behind the first byte
    for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_in[g] = i_data_byte;
        end else begin : g_body
            assign w_in[g] = i_scan_start ? 8'd0 : w_q[g-1];
        end
        wbss_cell #(.IDX(g)) u_cell (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl),
            .i_byte (w_in[g]),
            .i_len  (w_len),
            .i_sig  (w_sig),
            .i_wild (r_wild),
            .o_byte (w_q[g]),
            .o_hit  (w_hit[g])
        );
    end

    assign w_match  = !w_empty && (LEN_W'(n_cnt) >= w_len) && (&w_hit);
    assign w_at_end = (w_cur + ADDR_W'(1)) == r_end_addr;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo     <= '0;
            r_pat_hi     <= '0;
            r_wild       <= '0;
            r_len        <= LEN_W'(1);
            r_start_addr <= '0;
            r_end_addr   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PAT_LO: r_pat_lo     <= i_cfg_data;
                CFG_PAT_HI: r_pat_hi     <= i_cfg_data;
                CFG_WILD:   r_wild       <= i_cfg_data[WILD_W-1:0];
                CFG_LEN:    r_len        <= i_cfg_data[LEN_W-1:0];
                CFG_START:  r_start_addr <= i_cfg_data[ADDR_W-1:0];
                CFG_END:    r_end_addr   <= i_cfg_data[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    // Advance the scan state on each active transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur      <= '0;
            r_cnt      <= '0;
            r_finished <= 1'b1;
        end else if (w_active) begin
            if (w_empty) begin
                r_cur      <= w_cur;
                r_cnt      <= '0;
                r_finished <= 1'b1;
            end else begin
                r_cnt      <= n_cnt;
                r_finished <= w_match || w_at_end;
                r_cur      <= (w_match || w_at_end) ? w_cur : w_cur + ADDR_W'(1);
            end
        end
    end

    // Output register: load a result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_active && (w_empty || w_match || w_at_end)) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_active && (w_empty || w_match || w_at_end)) begin
            r_out_found <= w_match;
            r_out_addr  <= w_match ? (w_cur - ADDR_W'(w_len - LEN_W'(1))) : '0;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_found         = r_out_found;
    assign o_match_address = r_out_addr;

    // A not-found result always carries a zero address
    a_nf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_found |-> r_out_addr == '0)
        else $error("not-found result with nonzero address");

    // A pending result means the scan that gave it has finished
    a_res_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_finished)
        else $error("result pending while scan still running");

    // Fill count never passes the cell count
    a_cnt_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_PATTERN))
        else $error("window fill count overflow");

endmodule

>>> rtl/wbss_cell.sv
// One window cell: holds one byte and compares its incoming byte with
// the signature byte that lines up with it. Depends on wbss_pkg.
module wbss_cell import wbss_pkg::*; #(
    parameter int IDX = 0
) (
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic [7:0]       i_byte,
    input  logic [LEN_W-1:0] i_len,
    input  t_sig             i_sig,
    input  logic [WILD_W-1:0] i_wild,
    output logic [7:0]       o_byte,
    output logic             o_hit
);

    localparam logic [LEN_W-1:0] POS = LEN_W'(IDX);

    logic [7:0]           r_byte;
    logic [LEN_W-1:0]     w_sel_full;
    logic [SIG_IDX_W-1:0] w_sel;
    logic                 w_in_use;

    // Window slot POS lines up with signature byte len-1-POS
    assign w_sel_full = i_len - POS - LEN_W'(1);
    assign w_sel      = w_sel_full[SIG_IDX_W-1:0];
    assign w_in_use   = (POS < i_len);

    // Compare the byte that enters this slot on the current transaction
    assign o_hit = !w_in_use || i_wild[w_sel] || (i_byte == i_sig[w_sel]);

    // Hold, clear or take the byte handed over from the neighbor
    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_byte <= 8'd0;
        end else if (i_ctl.load) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

>>> bench/wbss_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the wildcard byte signature scanner: snoops the register port
// and both channels, predicts each scan outcome and checks every result field.
// Depends on wbss_pkg for register indexes and field widths.
module wbss_checker import wbss_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [7:0]        i_data_byte,
    input  logic              i_scan_start,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic              i_found,
    input  logic [ADDR_W-1:0] i_match_address,
    output int                o_fail_count,
    output int                o_pending
);

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] addr;
    } t_outcome;

    // Shadow copy of the register file
    logic [CFG_W-1:0]  pat_lo;
    logic [CFG_W-1:0]  pat_hi;
    logic [WILD_W-1:0] wild_mask;
    logic [LEN_W-1:0]  len_reg;
    logic [ADDR_W-1:0] range_start;
    logic [ADDR_W-1:0] range_end;

    // Shadow copy of the scan state; window[0] holds the newest byte
    logic [SIG_BYTES-1:0][7:0] window;
    logic [ADDR_W-1:0]         scan_addr;
    int                        window_fill;
    logic                      scan_idle;

    t_outcome outcome_q[$];
    int       fail_count = 0;

    assign o_fail_count = fail_count;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        fail_count++;
    endtask

    task automatic clear_model();
        pat_lo      = '0;
        pat_hi      = '0;
        wild_mask   = '0;
        len_reg     = LEN_W'(1);
        range_start = '0;
        range_end   = '0;
        window      = '0;
        scan_addr   = '0;
        window_fill = 0;
        scan_idle   = 1'b1;
        outcome_q.delete();
    endtask

    // Signature length in use: zero acts as one, anything above the cap saturates
    function automatic int sig_len();
        if (len_reg == 0)
            return 1;
        if (len_reg > SIG_BYTES)
            return SIG_BYTES;
        return int'(len_reg);
    endfunction

    task automatic write_shadow(input logic [2:0] idx, input logic [CFG_W-1:0] val);
        case (t_cfg_idx'(idx))
            CFG_PAT_LO: pat_lo      = val;
            CFG_PAT_HI: pat_hi      = val;
            CFG_WILD:   wild_mask   = val[WILD_W-1:0];
            CFG_LEN:    len_reg     = val[LEN_W-1:0];
            CFG_START:  range_start = val[ADDR_W-1:0];
            CFG_END:    range_end   = val[ADDR_W-1:0];
            default: ;
        endcase
    endtask

    // Advance the scan by one byte and queue the outcome it produces, if any
    task automatic scan_step(input logic [7:0] b, input logic s);
        logic [SIG_BYTES-1:0][7:0] sig;
        t_outcome                  res;
        int                        n;
        logic                      hit;
        sig = {pat_hi, pat_lo};
        if (s) begin
            window      = '0;
            window_fill = 0;
            scan_addr   = range_start;
            scan_idle   = 1'b0;
            if (range_end <= range_start) begin
                // empty range: report not-found at once
                scan_idle = 1'b1;
                res       = '{found: 1'b0, addr: '0};
                outcome_q.push_back(res);
                return;
            end
        end else if (scan_idle) begin
            return;
        end

        window = {window[SIG_BYTES-2:0], b};
        if (window_fill < SIG_BYTES)
            window_fill++;

        n   = sig_len();
        hit = (window_fill >= n);
        for (int i = 0; i < SIG_BYTES; i++) begin
            if (i < n) begin
                if (!wild_mask[i] && sig[i] != window[n-1-i])
                    hit = 1'b0;
            end
        end

        if (hit) begin
            scan_idle = 1'b1;
            res       = '{found: 1'b1, addr: scan_addr - ADDR_W'(n - 1)};
            outcome_q.push_back(res);
        end else if (scan_addr + 1 == range_end) begin
            scan_idle = 1'b1;
            res       = '{found: 1'b0, addr: '0};
            outcome_q.push_back(res);
        end else begin
            scan_addr = scan_addr + 1;
        end
    endtask

    // Check results first: a result at this edge belongs to an earlier byte
    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            clear_model();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (outcome_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result found=%0b addr=%h",
                                              i_found, i_match_address));
                end else begin
                    want = outcome_q.pop_front();
                    if (i_found !== want.found)
                        report_mismatch($sformatf("found %b, expected %b",
                                                  i_found, want.found));
                    if (i_match_address !== want.addr)
                        report_mismatch($sformatf("match_address %h, expected %h",
                                                  i_match_address, want.addr));
                end
            end
            if (i_cfg_we)
                write_shadow(i_cfg_index, i_cfg_data);
            if (i_in_valid && i_in_ready)
                scan_step(i_data_byte, i_scan_start);
        end
        o_pending <= outcome_q.size();
    end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// Top of the scanner testbench: clock, reset, register writes, byte stimulus
// and result back-pressure. Needs wbss_pkg, the scanner RTL and wbss_checker.
module tb_top;
    import wbss_pkg::*;

    localparam int CYCLE_LIMIT = 200_000;

    logic              i_clk           = 1'b0;
    logic              i_rst_n         = 1'b0;
    logic              i_cfg_we        = 1'b0;
    logic [2:0]        i_cfg_index     = CFG_PAT_LO;
    logic [CFG_W-1:0]  i_cfg_data      = '0;
    logic              i_valid         = 1'b0;
    logic [7:0]        i_data_byte     = 8'h00;
    logic              i_scan_start    = 1'b0;
    logic              i_ready         = 1'b0;
    logic              o_ready;
    logic              o_valid;
    logic              o_found;
    logic [ADDR_W-1:0] o_match_address;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int bytes_fed   = 0;
    int scans       = 0;
    bit calm        = 1'b0;
    bit busy        = 1'b0;

    // Register values last written
    logic [CFG_W-1:0]  reg_pat_lo;
    logic [CFG_W-1:0]  reg_pat_hi;
    logic [WILD_W-1:0] reg_wild;
    logic [LEN_W-1:0]  reg_len;
    logic [ADDR_W-1:0] reg_start;
    logic [ADDR_W-1:0] reg_end;

    wildcard_byte_signature_scanner uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_data_byte     (i_data_byte),
        .i_scan_start    (i_scan_start),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_found         (o_found),
        .o_match_address (o_match_address)
    );

    wbss_checker chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_valid),
        .i_in_ready      (o_ready),
        .i_data_byte     (i_data_byte),
        .i_scan_start    (i_scan_start),
        .i_out_valid     (o_valid),
        .i_out_ready     (i_ready),
        .i_found         (o_found),
        .i_match_address (o_match_address),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always #5 i_clk = ~i_clk;

    // Stall the result channel at random, except during the calm stretch
    always @(posedge i_clk) begin
        i_ready <= calm || ($urandom_range(0, 99) >= 16);
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Offer one byte, with an optional idle gap, and hold it until accepted
    task automatic send_byte(input logic [7:0] b, input logic s);
        while (!calm && $urandom_range(0, 99) < 16) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_data_byte  <= b;
        i_scan_start <= s;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
    endtask

    // Drop valid and wait until every predicted result has come out
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Write all six registers on consecutive cycles
    task automatic program_regs(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi,
                                input logic [WILD_W-1:0] wild, input logic [LEN_W-1:0] len,
                                input logic [ADDR_W-1:0] first, input logic [ADDR_W-1:0] last);
        reg_pat_lo = lo;
        reg_pat_hi = hi;
        reg_wild   = wild;
        reg_len    = len;
        reg_start  = first;
        reg_end    = last;
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_PAT_LO;
        i_cfg_data  <= lo;
        @(posedge i_clk);
        i_cfg_index <= CFG_PAT_HI;
        i_cfg_data  <= hi;
        @(posedge i_clk);
        i_cfg_index <= CFG_WILD;
        i_cfg_data  <= CFG_W'(wild);
        @(posedge i_clk);
        i_cfg_index <= CFG_LEN;
        i_cfg_data  <= CFG_W'(len);
        @(posedge i_clk);
        i_cfg_index <= CFG_START;
        i_cfg_data  <= CFG_W'(first);
        @(posedge i_clk);
        i_cfg_index <= CFG_END;
        i_cfg_data  <= CFG_W'(last);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // One scan over the configured range: mostly signature-laden data, some
    // planted matches (a few corrupted), the odd abandoned scan and stray bytes
    task automatic random_scan(output bit left_busy);
        logic [SIG_BYTES-1:0][7:0] sig;
        logic [7:0]                bytes [48];
        int                        span;
        int                        n;
        int                        p;
        int                        fed;
        sig  = {reg_pat_hi, reg_pat_lo};
        span = (reg_end > reg_start) ? int'(reg_end - reg_start) : 0;
        n    = (reg_len == 0) ? 1 : (reg_len > SIG_BYTES) ? SIG_BYTES : int'(reg_len);
        for (int i = 0; i < span; i++)
            bytes[i] = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                    : sig[$urandom_range(0, n - 1)];
        if (span >= n && $urandom_range(0, 99) < 70) begin
            p = $urandom_range(0, span - n);
            for (int j = 0; j < n; j++)
                if (!reg_wild[j])
                    bytes[p + j] = sig[j];
            if ($urandom_range(0, 4) == 0)
                bytes[p + $urandom_range(0, n - 1)] ^= 8'h01 << $urandom_range(0, 7);
        end

        left_busy = 1'b0;
        if (span == 0) begin
            send_byte(8'($urandom), 1'b1);
            fed = 1;
        end else begin
            fed = span;
            if (span >= 2 && $urandom_range(0, 9) == 0) begin
                fed       = $urandom_range(1, span - 1);
                left_busy = 1'b1;
            end
            for (int i = 0; i < fed; i++)
                send_byte(bytes[i], i == 0);
        end
        bytes_fed += fed;

        // stray bytes with no scan running are dropped by the block
        if (!left_busy)
            repeat ($urandom_range(0, 2)) send_byte(8'($urandom), 1'b0);
    endtask

    initial begin
        logic [LEN_W-1:0]  len;
        logic [WILD_W-1:0] wild;
        logic [ADDR_W-1:0] first;
        logic [ADDR_W-1:0] last;
        int                span;
        int                r;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values: a stray byte is dropped, then an empty range
        send_byte(8'h5A, 1'b0);
        send_byte(8'h00, 1'b1);
        settle();

        // Length zero acts as one; match at the top address on the last byte,
        // then a fresh scan of the same single byte that misses
        program_regs(64'hFF, 64'h0, 16'h0000, 5'd0, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
        settle();

        // Empty range with end below start
        program_regs(64'h5AA5_FF00, 64'h0, 16'h0002, 5'd4, 32'hFFFF_FFFF, 32'h0);
        send_byte(8'h00, 1'b1);
        settle();

        // Range shorter than the signature
        program_regs(64'h5AA5_FF00, 64'h0, 16'h0002, 5'd4, 32'd10, 32'd13);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b0);
        settle();

        // Restart in mid-scan, wildcard byte, match, then a dropped byte
        program_regs(64'h5AA5_FF00, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0002, 5'd4, 32'd100, 32'd110);
        send_byte(8'h00, 1'b1);
        send_byte(8'h11, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h77, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h33, 1'b0);
        settle();

        // Random scans; reconfigure only while the block is idle
        busy = 1'b0;
        while (bytes_fed < 400) begin
            calm = (scans >= 12 && scans < 22);
            if (!busy && $urandom_range(0, 99) < 60) begin
                settle();
                r   = $urandom_range(0, 99);
                len = (r < 5)  ? LEN_W'(0) :
                      (r < 12) ? LEN_W'($urandom_range(17, 31)) :
                                 LEN_W'($urandom_range(1, 16));
                r    = $urandom_range(0, 9);
                wild = (r == 0) ? 16'h0000 :
                       (r == 1) ? 16'hFFFF : WILD_W'($urandom & $urandom & $urandom);
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    first = $urandom | 32'h4;
                    last  = first - $urandom_range(0, 2);
                end else begin
                    span = (r < 88) ? $urandom_range(1, 24) : $urandom_range(25, 48);
                    r    = $urandom_range(0, 9);
                    if (r == 0)
                        first = '0;
                    else if (r == 1)
                        first = 32'hFFFF_FFFF - ADDR_W'(span);
                    else
                        first = $urandom_range(0, 32'hFFFF_FFFF - span);
                    last = first + ADDR_W'(span);
                end
                program_regs({$urandom, $urandom}, {$urandom, $urandom}, wild, len,
                             first, last);
            end
            random_scan(busy);
            scans++;
        end
        calm = 1'b0;

        settle();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
